/* hw/rtl/pmc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID motor controller package
// Shared widths, register indexes and saturating helpers.
// ----------------------------------------------------------------------------
package pmc_pkg;

	localparam int TAPS       = 64;
	localparam int TAP_AW     = $clog2(TAPS);
	localparam int LEN_W      = 7;
	localparam int HIST_W     = 32;
	localparam int COEF_W     = 24;
	localparam int GAIN_W     = 24;
	localparam int DT_W       = 17;
	localparam int IN_W       = 112;
	localparam int OUT_W      = 88;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int MUL_A_W    = 35;
	localparam int MUL_B_W    = 25;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int DIV_N_W    = 58;
	localparam int DIV_D_W    = 17;
	localparam int DIV_CNT_W  = $clog2(DIV_N_W);
	localparam int DRIVE_W    = 18;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_FF   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VEL_MODE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_SCL  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FIR_LEN   = 3'd6;

	localparam logic [23:0] RATE_SCALE_RST = 24'd2796203;

	// Clamp to plus or minus one in Q1.16.
	function automatic logic signed [DRIVE_W-1:0] clamp_one(input logic signed [63:0] v);
		logic signed [DRIVE_W-1:0] r;
		if (v < -64'sd65536)
			r = -18'sd65536;
		else if (v > 64'sd65536)
			r = 18'sd65536;
		else
			r = DRIVE_W'(v);
		return r;
	endfunction

	// Saturate to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v < -64'sd2147483648)
			r = 32'sh8000_0000;
		else if (v > 64'sd2147483647)
			r = 32'sh7FFF_FFFF;
		else
			r = 32'(v);
		return r;
	endfunction

endpackage

/* hw/rtl/pmc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module pmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/pmc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pmc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pmc_pkg::DIV_N_W-1:0]   dividend,
	input  logic [pmc_pkg::DIV_D_W-1:0]   divisor,
	output logic                          busy,
	output logic                          done,
	output logic [pmc_pkg::DIV_N_W-1:0]   quotient
);
	import pmc_pkg::*;

	logic [DIV_D_W:0]   rem_q;
	logic [DIV_N_W-1:0] quo_q;
	logic [DIV_D_W-1:0] dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DIV_D_W:0]   trial;
	logic               take;

	// Trial subtraction for the next quotient bit.
	always_comb begin
		trial = {rem_q[DIV_D_W-1:0], quo_q[DIV_N_W-1]};
		take  = (trial >= {1'b0, dsr_q});
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Datapath: the quotient shifts in where the dividend shifts out.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? (trial - {1'b0, dsr_q}) : trial;
			quo_q <= {quo_q[DIV_N_W-2:0], take};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider started while busy");
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while still busy");

endmodule

/* hw/rtl/pid_motor_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID motor controller
// PID drive with feedforward and a setpoint FIR filter held in RAM.
// ----------------------------------------------------------------------------
// With the filter bypassed, a result passes once through the serial divider.
// With filter taps, the tap multiply loop runs first and the result takes two
// passes through the serial divider. Result stalls hold the sequencer.
// One control item is in work at a time; the next is taken in the cycle after
// the result is loaded, and a coefficient item is written in its transfer cycle.
// Reset clears control state and the history valid bits; the coefficient RAM
// is not cleared and no clearing pass is run.
module pid_motor_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pmc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pmc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// setpoint, measured, delta_time, coef_index, coef_value, zero fill
	input  logic [pmc_pkg::IN_W-1:0]        s_axis_tdata,
	// req_type
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// drive, error_value, filtered_target, zero fill
	output logic [pmc_pkg::OUT_W-1:0]       m_axis_tdata
);
	import pmc_pkg::*;

	typedef enum logic [15:0] {
		ST_IDLE  = 16'h0001,
		ST_HWR   = 16'h0002,
		ST_MAC   = 16'h0004,
		ST_FDIV  = 16'h0008,
		ST_FWAIT = 16'h0010,
		ST_MEAS  = 16'h0020,
		ST_ERR   = 16'h0040,
		ST_P     = 16'h0080,
		ST_IE    = 16'h0100,
		ST_IG    = 16'h0200,
		ST_IA    = 16'h0400,
		ST_ID    = 16'h0800,
		ST_DD    = 16'h1000,
		ST_DW    = 16'h2000,
		ST_FF    = 16'h4000,
		ST_SUM   = 16'h8000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q, gain_ff_q;
	logic                     velocity_mode_q;
	logic [23:0]              rate_scale_q;
	logic [LEN_W-1:0]         fir_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q        <= '0;
			gain_i_q        <= '0;
			gain_d_q        <= '0;
			gain_ff_q       <= '0;
			velocity_mode_q <= 1'b1;
			rate_scale_q    <= RATE_SCALE_RST;
			fir_length_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_P:   gain_p_q        <= cfg_data;
				REG_GAIN_I:   gain_i_q        <= cfg_data;
				REG_GAIN_D:   gain_d_q        <= cfg_data;
				REG_GAIN_FF:  gain_ff_q       <= cfg_data;
				REG_VEL_MODE: velocity_mode_q <= cfg_data[0];
				REG_RATE_SCL: rate_scale_q    <= cfg_data;
				REG_FIR_LEN:  fir_length_q    <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Input field unpacking.
	logic signed [31:0]       in_setpoint, in_measured;
	logic [DT_W-1:0]          in_dt;
	logic [TAP_AW-1:0]        in_coef_index;
	logic [COEF_W-1:0]        in_coef_value;
	logic                     in_xfer;
	logic [LEN_W-1:0]         len_next;

	assign in_setpoint   = s_axis_tdata[31:0];
	assign in_measured   = s_axis_tdata[63:32];
	assign in_dt         = s_axis_tdata[80:64];
	assign in_coef_index = s_axis_tdata[86:81];
	assign in_coef_value = s_axis_tdata[110:87];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign len_next      = (fir_length_q > LEN_W'(TAPS)) ? LEN_W'(TAPS) : fir_length_q;

	// Item and working registers.
	logic signed [31:0]       setpoint_q, measured_q, target_q, err_q;
	logic signed [31:0]       integ_q, prev_err_q;
	logic [DT_W-1:0]          dt_q;
	logic [LEN_W-1:0]         len_q, cnt_q;
	logic [TAP_AW-1:0]        wp_q;
	logic [TAPS-1:0]          hv_q;
	logic                     hv_s1, iss_s1, prd_s2;
	logic signed [63:0]       acc_q;
	logic                     neg_q;
	logic signed [DRIVE_W-1:0] pout_q, iout_q, dout_q;
	logic signed [PROD_W-1:0] prod_q;

	// Memories: setpoint history (circular, newest at wp_q) and coefficients.
	logic                     hist_we;
	logic [TAP_AW-1:0]        hist_waddr, hist_raddr;
	logic [HIST_W-1:0]        hist_rdata;
	logic [COEF_W-1:0]        coef_rdata;
	logic                     coef_we;

	assign hist_we    = (state_q == ST_HWR);
	assign hist_waddr = wp_q + 1'b1;
	assign hist_raddr = wp_q - cnt_q[TAP_AW-1:0];
	assign coef_we    = in_xfer && s_axis_tuser;

	pmc_ram #(.WIDTH(HIST_W), .DEPTH(TAPS)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (setpoint_q),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	pmc_ram #(.WIDTH(COEF_W), .DEPTH(TAPS)) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (in_coef_index),
		.wdata (in_coef_value),
		.raddr (cnt_q[TAP_AW-1:0]),
		.rdata (coef_rdata)
	);

	// Shared divider.
	logic                     div_start, div_busy, div_done;
	logic [DIV_N_W-1:0]       div_dividend, div_quo;
	logic [DIV_D_W-1:0]       div_divisor;
	logic [63:0]              acc_abs;
	logic [PROD_W-1:0]        prod_abs;

	assign acc_abs  = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
	assign prod_abs = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);

	always_comb begin
		div_start    = 1'b0;
		div_dividend = DIV_N_W'(acc_abs >> 16);
		div_divisor  = DIV_D_W'(len_q);
		if (state_q == ST_FDIV) begin
			div_start = 1'b1;
		end else if (state_q == ST_DD) begin
			div_start    = 1'b1;
			div_dividend = DIV_N_W'(prod_abs);
			div_divisor  = dt_q;
		end
	end

	pmc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Shared multiplier operand selection.
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic                      mul_en;

	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			ST_MAC: begin
				mul_a = hv_s1 ? MUL_A_W'($signed(hist_rdata)) : '0;
				mul_b = MUL_B_W'($signed(coef_rdata));
			end
			ST_MEAS: begin
				mul_a = MUL_A_W'(measured_q);
				mul_b = $signed({1'b0, rate_scale_q});
			end
			ST_P: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = MUL_B_W'(gain_p_q);
			end
			ST_IE: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = $signed({{(MUL_B_W-DT_W){1'b0}}, dt_q});
			end
			ST_IG: begin
				mul_a = MUL_A_W'(prod_q >>> 16);
				mul_b = MUL_B_W'(gain_i_q);
			end
			ST_ID: begin
				mul_a = MUL_A_W'(err_q) - MUL_A_W'(prev_err_q);
				mul_b = MUL_B_W'(gain_d_q);
			end
			ST_FF: begin
				mul_a = MUL_A_W'(target_q);
				mul_b = MUL_B_W'(gain_ff_q);
			end
			default: mul_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en)
			prod_q <= mul_a * mul_b;
	end

	// Combinational helpers for the arithmetic steps.
	logic signed [63:0] quo_signed, meas_val, drive_sum;
	logic signed [31:0] err_next;
	logic               out_free;

	assign quo_signed = neg_q ? -$signed(64'(div_quo)) : $signed(64'(div_quo));
	assign meas_val   = velocity_mode_q ? 64'(prod_q >>> 24) : 64'(measured_q);
	assign err_next   = sat32(64'(target_q) - meas_val);
	assign drive_sum  = 64'(pout_q) + 64'(iout_q) + 64'(dout_q) + 64'(prod_q >>> 16);
	assign out_free   = !m_axis_tvalid || m_axis_tready;

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wp_q       <= '0;
			hv_q       <= '0;
			cnt_q      <= '0;
			iss_s1     <= 1'b0;
			prd_s2     <= 1'b0;
			integ_q    <= '0;
			prev_err_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && !s_axis_tuser)
						state_q <= (len_next == '0) ? ST_MEAS : ST_HWR;
				end
				ST_HWR: begin
					wp_q             <= hist_waddr;
					hv_q[hist_waddr] <= 1'b1;
					cnt_q            <= '0;
					iss_s1           <= 1'b0;
					prd_s2           <= 1'b0;
					state_q          <= ST_MAC;
				end
				ST_MAC: begin
					iss_s1 <= (cnt_q < len_q);
					prd_s2 <= iss_s1;
					if (cnt_q < len_q)
						cnt_q <= cnt_q + 1'b1;
					if (cnt_q == len_q && !iss_s1 && !prd_s2)
						state_q <= ST_FDIV;
				end
				ST_FDIV:  state_q <= ST_FWAIT;
				ST_FWAIT: if (div_done) state_q <= ST_MEAS;
				ST_MEAS:  state_q <= ST_ERR;
				ST_ERR:   state_q <= ST_P;
				ST_P:     state_q <= ST_IE;
				ST_IE:    state_q <= ST_IG;
				ST_IG:    state_q <= ST_IA;
				ST_IA:    state_q <= ST_ID;
				ST_ID:    state_q <= ST_DD;
				ST_DD:    state_q <= ST_DW;
				ST_DW:    if (div_done) state_q <= ST_FF;
				ST_FF:    state_q <= ST_SUM;
				ST_SUM: begin
					if (out_free) begin
						integ_q    <= 32'(iout_q);
						prev_err_q <= err_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Sequencer datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					setpoint_q <= in_setpoint;
					measured_q <= in_measured;
					dt_q       <= (in_dt == '0) ? DT_W'(1) : in_dt;
					len_q      <= len_next;
					target_q   <= in_setpoint;
				end
			end
			ST_HWR: acc_q <= '0;
			ST_MAC: begin
				hv_s1 <= hv_q[hist_raddr];
				if (prd_s2)
					acc_q <= acc_q + 64'(prod_q);
			end
			ST_FDIV: neg_q <= acc_q[63];
			ST_FWAIT: if (div_done) target_q <= sat32(quo_signed);
			ST_ERR:  err_q  <= err_next;
			ST_IE:   pout_q <= clamp_one(64'(prod_q >>> 16));
			ST_IA:   iout_q <= clamp_one(64'(integ_q) + 64'(prod_q >>> 16));
			ST_DD:   neg_q  <= prod_q[PROD_W-1];
			ST_DW:   if (div_done) dout_q <= clamp_one(quo_signed);
			default: ;
		endcase
	end

	// Output register decouples the result from the sequencer.
	logic                    out_valid_q;
	logic [OUT_W-1:0]        out_data_q;
	logic                    out_load;

	assign out_load = (state_q == ST_SUM) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_data_q <= {6'b0, target_q, err_q, clamp_one(drive_sum)};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_mac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (cnt_q <= len_q)) else $error("tap count overran length");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_axis_tvalid) else $error("result transfer lost");
	a_coef_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && s_axis_tuser) |=> (state_q == ST_IDLE))
		else $error("coefficient transfer started work");
	a_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_busy) else $error("divider busy while idle");

endmodule

/* tb/tb_pid_motor_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID motor controller testbench
// Drives control samples and coefficient writes through the stream ports
// under random burst and stall patterns. Between phases the testbench changes
// the registers, and checks every result against its own fixed-point model.
// ----------------------------------------------------------------------------
module tb_pid_motor_controller;
	import pmc_pkg::*;

	localparam bit REQ_SAMPLE = 1'b0;
	localparam bit REQ_COEF   = 1'b1;
	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE     = 250;

	typedef struct {
		bit                  req;
		logic signed [31:0]  sp;
		logic signed [31:0]  ms;
		logic [16:0]         dt;
		logic [5:0]          ci;
		logic signed [23:0]  cv;
	} motor_item_t;

	typedef struct {
		logic signed [17:0]  drive;
		logic signed [31:0]  err;
		logic signed [31:0]  tgt;
	} motor_result_t;

	// Scoreboard with a fixed-point model of the controller.
	class motor_scoreboard;
		longint        gp, gi, gd, gff;
		bit            vel;
		longint        rate;
		int            fir_len;
		int            hist[TAPS];
		int            coef[TAPS];
		longint        integ, prev_err;
		motor_result_t expected_q[$];
		int            fails;

		function new();
			gp = 0; gi = 0; gd = 0; gff = 0;
			vel = 1; rate = 2796203; fir_len = 0;
			foreach (hist[k]) begin
				hist[k] = 0;
				coef[k] = 0;
			end
			integ = 0; prev_err = 0; fails = 0;
		endfunction

		function longint clamp1(longint v);
			return v < -65536 ? -65536 : (v > 65536 ? 65536 : v);
		endfunction

		function longint sat(longint v);
			return v < -64'sd2147483648 ? -64'sd2147483648 :
				(v > 64'sd2147483647 ? 64'sd2147483647 : v);
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
			case (idx)
				REG_GAIN_P:   gp = longint'($signed(val));
				REG_GAIN_I:   gi = longint'($signed(val));
				REG_GAIN_D:   gd = longint'($signed(val));
				REG_GAIN_FF:  gff = longint'($signed(val));
				REG_VEL_MODE: vel = val[0];
				REG_RATE_SCL: rate = longint'(val);
				REG_FIR_LEN:  fir_len = int'(val[6:0]);
				default: ;
			endcase
		endfunction

		// Note an accepted input transfer and work out its result.
		function void note_input(motor_item_t it);
			longint sp, ms, dt, tgt, meas, err, po, io, dd, ff, sum;
			int len;
			motor_result_t r;
			sp = it.sp;
			ms = it.ms;
			dt = longint'(it.dt);
			if (it.req) begin
				coef[it.ci] = int'(it.cv);
				return;
			end
			if (dt == 0)
				dt = 1;
			len = fir_len > TAPS ? TAPS : fir_len;
			if (len == 0) begin
				tgt = sp;
			end else begin
				for (int k = TAPS - 1; k > 0; k--)
					hist[k] = hist[k-1];
				hist[0] = int'(sp);
				sum = 0;
				for (int k = 0; k < len; k++)
					sum += longint'(hist[k]) * longint'(coef[k]);
				tgt = sat(sum / (longint'(len) * 65536));
			end
			meas = vel ? (ms * rate) >>> 24 : ms;
			err = sat(tgt - meas);
			po = clamp1((gp * err) >>> 16);
			io = clamp1(integ + ((gi * ((err * dt) >>> 16)) >>> 16));
			integ = io;
			dd = clamp1((gd * (err - prev_err)) / dt);
			ff = (gff * tgt) >>> 16;
			r.drive = 18'(clamp1(po + io + dd + ff));
			r.err = 32'(err);
			r.tgt = 32'(tgt);
			prev_err = err;
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $realtime, msg);
			fails++;
		endtask

		// Check one output transfer against the oldest expectation.
		task check_result(logic [OUT_W-1:0] d);
			motor_result_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result %h", d));
				return;
			end
			e = expected_q.pop_front();
			if (d[17:0] !== e.drive)
				report($sformatf("drive %0d, expected %0d", $signed(d[17:0]), e.drive));
			if (d[49:18] !== e.err)
				report($sformatf("error %0d, expected %0d", $signed(d[49:18]), e.err));
			if (d[81:50] !== e.tgt)
				report($sformatf("target %0d, expected %0d", $signed(d[81:50]), e.tgt));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_W-1:0]       s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_W-1:0]      m_axis_tdata;

	motor_scoreboard sb = new();
	int burst_left = 0;
	int stall_left = 0;
	int quiet_cycles = 0;
	int idle_cycles = 0;

	pid_motor_controller i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Receiver: stalls of random length, with long stretches of no stalls.
	always @(negedge clk) begin
		quiet_cycles = (quiet_cycles + 1) % 3000;
		if (stall_left > 0) begin
			m_axis_tready = 1'b0;
			stall_left--;
		end else begin
			m_axis_tready = 1'b1;
			if (quiet_cycles < 2000 && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 30);
		end
	end

	// Output monitor and watchdog.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
		if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic signed [31:0] pick32();
		case ($urandom_range(0, 6))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $signed(32'($urandom_range(0, 262143))) - 131072;
			3: return $signed(32'($urandom_range(0, 2097151))) - 1048576;
			4: return $signed(32'($urandom_range(0, 33554431))) - 16777216;
			default: return $signed($urandom());
		endcase
	endfunction

	function automatic logic [16:0] pick_dt();
		case ($urandom_range(0, 5))
			0: return 17'd0;
			1: return 17'd1;
			2: return 17'h1FFFF;
			3: return 17'($urandom_range(600, 700));
			default: return 17'($urandom());
		endcase
	endfunction

	function automatic logic [23:0] pick_gain();
		case ($urandom_range(0, 3))
			0: return 24'($signed(24'($urandom_range(0, 131071))) - 65536);
			1: return 24'($signed(24'($urandom_range(0, 8191))) - 4096);
			default: return 24'($urandom());
		endcase
	endfunction

	// Present one item and wait for its transfer; then keep up the burst pattern.
	task automatic send_item(motor_item_t it);
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tuser = it.req;
		s_axis_tdata = {1'b0, it.cv, it.ci, it.dt, it.ms, it.sp};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_input(it);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 20);
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(0, 10)) @(negedge clk);
		end
	endtask

	task automatic send_sample(logic signed [31:0] sp, logic signed [31:0] ms,
			logic [16:0] dt);
		motor_item_t it;
		it.req = REQ_SAMPLE;
		it.sp = sp;
		it.ms = ms;
		it.dt = dt;
		it.ci = 6'($urandom());
		it.cv = 24'($urandom());
		send_item(it);
	endtask

	task automatic send_coef(logic [5:0] ci, logic signed [23:0] cv);
		motor_item_t it;
		it.req = REQ_COEF;
		it.sp = $urandom();
		it.ms = $urandom();
		it.dt = 17'($urandom());
		it.ci = ci;
		it.cv = cv;
		send_item(it);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_reg(idx, val);
	endtask

	// Wait until every expected result is in and the block has settled.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_all(logic [23:0] p, logic [23:0] i, logic [23:0] d,
			logic [23:0] ff, logic v, logic [23:0] rs, logic [6:0] len);
		drain();
		cfg_write(REG_GAIN_P, p);
		cfg_write(REG_GAIN_I, i);
		cfg_write(REG_GAIN_D, d);
		cfg_write(REG_GAIN_FF, ff);
		cfg_write(REG_VEL_MODE, 24'(v));
		cfg_write(REG_RATE_SCL, rs);
		cfg_write(REG_FIR_LEN, 24'(len));
	endtask

	task automatic random_items(int n);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 9) == 0)
				send_coef(6'($urandom()), 24'($urandom()));
			else
				send_sample(pick32(), pick32(), pick_dt());
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Fill the whole coefficient store before any filter is enabled.
		for (int k = 0; k < TAPS; k++)
			send_coef(6'(k), k == 0 ? 24'sh7FFFFF : (k == 63 ? 24'sh800000 : 24'sh010000));

		// Directed samples with reset settings: extremes of every field.
		send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 17'd0);
		send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 17'h1FFFF);
		send_sample(32'sh0001_0000, 32'sh0000_0000, 17'd1);
		send_sample(-32'sh0001_0000, 32'sh0001_0000, 17'd655);

		set_all(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0, 24'd0, 7'd64);
		send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 17'd0);
		send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 17'h1FFFF);
		send_sample(32'sh0000_1000, 32'sh0000_0800, 17'd655);
		send_coef(6'd63, 24'sh7FFFFF);
		send_sample(32'sh0000_0000, 32'sh0000_0000, 17'd1);

		set_all(24'h800000, 24'h800000, 24'h800000, 24'h800000, 1'b1, 24'hFFFFFF, 7'd127);
		send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 17'd1);
		send_sample(32'sh8000_0000, 32'sh8000_0000, 17'h1FFFF);
		send_sample(32'sh0000_4000, -32'sh0000_4000, 17'd0);

		set_all(24'h010000, 24'h000100, 24'h000010, 24'h008000, 1'b1, 24'd2796203, 7'd1);
		send_sample(32'sh0002_0000, 32'sh0001_0000, 17'd655);
		send_sample(-32'sh0002_0000, 32'sh0000_0100, 17'd655);
		send_sample(32'sh0000_0000, 32'sh7FFF_FFFF, 17'd655);

		// Random phases, each with fresh register settings.
		for (int ph = 0; ph < 9; ph++) begin
			set_all(pick_gain(), pick_gain(), pick_gain(), pick_gain(), 1'($urandom()),
				ph == 0 ? 24'hFFFFFF : 24'($urandom()),
				ph % 3 == 0 ? 7'd0 : 7'($urandom_range(0, 127)));
			random_items(200);
		end

		drain();
		if (sb.fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
